FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; included by the top level.
// Empty when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only out of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: hw/rtl/hdm_pkg.sv
// Shared types and constants for the holonomic drive mixer.
// No dependencies.
`timescale 1ns / 1ps
package hdm_pkg;
  localparam int STAGES = 16;
  localparam logic [6:0] DEAD_ZONE_RESET = 7'd10;

  // Per-transaction sideband that rides along the pipeline.
  typedef struct packed {
    logic signed [7:0] rot;
    logic xpos;
    logic xneg;
    logic ypos;
    logic yneg;
    logic ratio_neg;
  } side_t;
endpackage

FILE: hw/rtl/hdm_front.sv
// Front stage: axis conditioning, dead zone, squares and rotate scaling.
// Depends on hdm_pkg.
`timescale 1ns / 1ps
module hdm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic signed [7:0] in_stick_x,
  input  logic signed [7:0] in_stick_y,
  input  logic signed [7:0] in_turn_axis,
  input  logic [6:0]        dead_zone,
  output logic              out_valid,
  output logic [15:0]       out_sum,
  output logic [14:0]       out_numm,
  output hdm_pkg::side_t    out_side
);
  import hdm_pkg::*;

  logic signed [8:0] xs, ys;
  logic [7:0]  ax, ay, axe, aye;
  logic        keepx, keepy;
  logic [15:0] sqx, sqy;
  logic [7:0]  tm;
  logic [13:0] p;
  logic [22:0] pk;
  logic [7:0]  qe, q;
  logic [13:0] r;
  logic        valid_r;
  logic [15:0] sum_r, sum_nxt;
  logic [14:0] numm_r, numm_nxt;
  side_t       side_r, side_nxt;

  always_comb begin
    xs    = {in_stick_x[7], in_stick_x};
    ys    = -{in_stick_y[7], in_stick_y};
    ax    = xs[8] ? 8'(-xs) : xs[7:0];
    ay    = ys[8] ? 8'(-ys) : ys[7:0];
    keepx = ax >= {1'b0, dead_zone};
    keepy = ay >= {1'b0, dead_zone};
    axe   = keepx ? ax : 8'd0;
    aye   = keepy ? ay : 8'd0;
    sqx   = axe * axe;
    sqy   = aye * aye;
    sum_nxt  = sqx + sqy;
    numm_nxt = (sqx >= sqy) ? 15'(sqx - sqy) : 15'(sqy - sqx);
    // rotate * 100 / 127 on the magnitude: reciprocal then one correction
    tm = in_turn_axis[7] ? 8'(-{in_turn_axis[7], in_turn_axis}) : 8'(in_turn_axis);
    p  = tm * 7'd100;
    pk = p * 10'd516;
    qe = 8'(pk >> 16);
    r  = p - 14'(qe) * 14'd127;
    q  = (r >= 14'd127) ? qe + 8'd1 : qe;
    side_nxt.rot       = in_turn_axis[7] ? -$signed(q) : $signed(q);
    side_nxt.xpos      = keepx && !xs[8] && (xs != 9'sd0);
    side_nxt.xneg      = keepx && xs[8];
    side_nxt.ypos      = keepy && !ys[8] && (ys != 9'sd0);
    side_nxt.yneg      = keepy && ys[8];
    side_nxt.ratio_neg = sqx < sqy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      numm_r <= numm_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_sum   = sum_r;
  assign out_numm  = numm_r;
  assign out_side  = side_r;
endmodule

FILE: hw/rtl/hdm_root_div.sv
// Bit-per-stage square root of sum<<16 and restoring divide |num|<<15 / sum.
// Depends on hdm_pkg.
`timescale 1ns / 1ps
module hdm_root_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [15:0]    in_sum,
  input  logic [14:0]    in_numm,
  input  hdm_pkg::side_t in_side,
  output logic           out_valid,
  output logic [15:0]    out_root,
  output logic [15:0]    out_ratio,
  output hdm_pkg::side_t out_side
);
  import hdm_pkg::*;

  logic        v_r    [STAGES];
  logic [31:0] n_r    [STAGES];
  logic [31:0] res_r  [STAGES];
  logic [30:0] remd_r [STAGES];
  logic [15:0] q_r    [STAGES];
  logic [15:0] sum_r  [STAGES];
  side_t       side_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * k);
    localparam int DSH = STAGES - 1 - k;
    logic        v_in;
    logic [31:0] n_in, res_in, n_nxt, res_nxt, trial;
    logic [30:0] remd_in, remd_nxt, dtrial;
    logic [15:0] q_in, q_nxt, sum_in;
    side_t       side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign n_in    = {in_sum, 16'h0000};
      assign res_in  = 32'd0;
      assign remd_in = {1'b0, in_numm, 15'h0000};
      assign q_in    = 16'd0;
      assign sum_in  = in_sum;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign n_in    = n_r[k-1];
      assign res_in  = res_r[k-1];
      assign remd_in = remd_r[k-1];
      assign q_in    = q_r[k-1];
      assign sum_in  = sum_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (n_in >= trial) begin
        n_nxt   = n_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
      dtrial = {15'd0, sum_in} << DSH;
      q_nxt  = q_in;
      if (remd_in >= dtrial) begin
        remd_nxt   = remd_in - dtrial;
        q_nxt[DSH] = 1'b1;
      end else begin
        remd_nxt = remd_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_nxt;
        res_r[k]  <= res_nxt;
        remd_r[k] <= remd_nxt;
        q_r[k]    <= q_nxt;
        sum_r[k]  <= sum_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_root  = res_r[STAGES-1][15:0];
  assign out_ratio = q_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];
endmodule

FILE: hw/rtl/hdm_mix.sv
// Power scaling, power*ratio, wheel selection, rotate mix and saturation.
// Depends on hdm_pkg.
`timescale 1ns / 1ps
module hdm_mix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [15:0]       in_root,
  input  logic [15:0]       in_ratio,
  input  hdm_pkg::side_t    in_side,
  output logic              out_valid,
  output logic signed [7:0] out_front_left_power,
  output logic signed [7:0] out_front_right_power,
  output logic signed [7:0] out_back_right_power,
  output logic signed [7:0] out_back_left_power
);
  import hdm_pkg::*;

  // trunc toward zero of (term + rot) / 256, clamped to +-100
  function automatic logic signed [7:0] wheel_sat(input logic signed [17:0] term,
                                                  input logic signed [17:0] rq);
    logic signed [17:0] v, t;
    v = term + rq;
    t = v[17] ? -((-v) >>> 8) : (v >>> 8);
    if (t > 18'sd100)       wheel_sat = 8'sd100;
    else if (t < -18'sd100) wheel_sat = -8'sd100;
    else                    wheel_sat = t[7:0];
  endfunction

  logic [4:0]  v_r;
  logic [22:0] pa_r, pb_r;
  logic [38:0] m_r;
  logic [15:0] pw_r, pwd_r, pam_r;
  logic [15:0] ra_r, rb_r, rc_r;
  side_t       sa_r, sb_r, sc_r, sd_r;
  logic [15:0] qe, pw_nxt;
  logic [22:0] rem;
  logic [31:0] prod;
  logic signed [17:0] pws, pas, rq, ta, tb, tc, td;
  logic signed [7:0]  fl_r, fr_r, br_r, bl_r;

  always_comb begin
    qe     = 16'(m_r >> 22);
    rem    = pb_r - 23'(qe) * 23'd127;
    pw_nxt = (rem >= 23'd127) ? qe + 16'd1 : qe;
    prod   = pw_r * rc_r;
  end

  always_comb begin
    pws = $signed({2'b00, pwd_r});
    pas = sd_r.ratio_neg ? -$signed({2'b00, pam_r}) : $signed({2'b00, pam_r});
    rq  = {{2{sd_r.rot[7]}}, sd_r.rot, 8'h00};
    if (sd_r.yneg && sd_r.xpos) begin
      ta = pws;  tb = -pas; tc = -pas; td = pws;
    end else if (sd_r.yneg && sd_r.xneg) begin
      ta = -pas; tb = pws;  tc = pws;  td = -pas;
    end else if (sd_r.ypos && sd_r.xneg) begin
      ta = -pws; tb = pas;  tc = pas;  td = -pws;
    end else if (sd_r.ypos && sd_r.xpos) begin
      ta = pas;  tb = -pws; tc = -pws; td = pas;
    end else if (sd_r.yneg) begin
      ta = pws;  tb = pws;  tc = pws;  td = pws;
    end else if (sd_r.ypos) begin
      ta = -pws; tb = -pws; tc = -pws; td = -pws;
    end else if (sd_r.xpos) begin
      ta = pws;  tb = -pws; tc = -pws; td = pws;
    end else if (sd_r.xneg) begin
      ta = -pws; tb = pws;  tc = pws;  td = -pws;
    end else begin
      ta = '0;   tb = '0;   tc = '0;   td = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= in_root * 7'd100;
      ra_r  <= in_ratio;
      sa_r  <= in_side;
      m_r   <= pa_r * 16'd33026;
      pb_r  <= pa_r;
      rb_r  <= ra_r;
      sb_r  <= sa_r;
      pw_r  <= pw_nxt;
      rc_r  <= rb_r;
      sc_r  <= sb_r;
      pam_r <= prod[30:15];
      pwd_r <= pw_r;
      sd_r  <= sc_r;
      fl_r  <= wheel_sat(ta, rq);
      fr_r  <= wheel_sat(tb, -rq);
      br_r  <= wheel_sat(tc, rq);
      bl_r  <= wheel_sat(td, -rq);
    end
  end

  assign out_valid             = v_r[4];
  assign out_front_left_power  = fl_r;
  assign out_front_right_power = fr_r;
  assign out_back_right_power  = br_r;
  assign out_back_left_power   = bl_r;
endmodule

FILE: hw/rtl/holonomic_drive_mixer_top.sv
// Top level of the holonomic drive mixer: config register, stall control,
// pipeline. Depends on hdm_pkg, hdm_front, hdm_root_div, hdm_mix.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  stick_x, stick_y, turn_axis (s8)
//  out      output     out_valid/out_stall four wheel powers (s8, +-100)
//  cfg      input      cfg_valid/cfg_ready dead_zone (u7)
//
// One transaction per cycle while the pipeline is not held; stages: 1 front,
// 16 root/divide, 5 mix including the output register.
// The whole pipeline advances together; it holds when the output register is
// full and stalled, and in_stall is raised for exactly those cycles.
// Synchronous active-low reset clears valid bits; dead_zone resets to 10.
`timescale 1ns / 1ps
module holonomic_drive_mixer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] in_stick_x,
  input  logic signed [7:0] in_stick_y,
  input  logic signed [7:0] in_turn_axis,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_front_left_power,
  output logic signed [7:0] out_front_right_power,
  output logic signed [7:0] out_back_right_power,
  output logic signed [7:0] out_back_left_power,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_dead_zone
);
  import hdm_pkg::*;
`include "assert_macros.svh"

  logic [6:0]  dead_zone_r;
  logic        en;
  logic        f_valid, r_valid;
  logic [15:0] f_sum, r_root, r_ratio;
  logic [14:0] f_numm;
  side_t       f_side, r_side;

  // advance unless a finished result is held by the consumer
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= DEAD_ZONE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dead_zone_r <= cfg_dead_zone;
    end
  end

  hdm_front u_front (
    .clk, .rst_n, .en,
    .in_valid, .in_stick_x, .in_stick_y, .in_turn_axis,
    .dead_zone (dead_zone_r),
    .out_valid (f_valid), .out_sum (f_sum), .out_numm (f_numm), .out_side (f_side)
  );

  hdm_root_div u_root_div (
    .clk, .rst_n, .en,
    .in_valid (f_valid), .in_sum (f_sum), .in_numm (f_numm), .in_side (f_side),
    .out_valid (r_valid), .out_root (r_root), .out_ratio (r_ratio), .out_side (r_side)
  );

  hdm_mix u_mix (
    .clk, .rst_n, .en,
    .in_valid (r_valid), .in_root (r_root), .in_ratio (r_ratio), .in_side (r_side),
    .out_valid, .out_front_left_power, .out_front_right_power,
    .out_back_right_power, .out_back_left_power
  );

  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "output valid after reset")
  `ASSERT_RST(a_front_range, out_valid |-> (out_front_left_power <= 8'sd100 && out_front_left_power >= -8'sd100 && out_front_right_power <= 8'sd100 && out_front_right_power >= -8'sd100), "front power out of range")
  `ASSERT_RST(a_back_range, out_valid |-> (out_back_left_power <= 8'sd100 && out_back_left_power >= -8'sd100 && out_back_right_power <= 8'sd100 && out_back_right_power >= -8'sd100), "back power out of range")
  `ASSERT_RST(a_cfg_write, cfg_valid |=> dead_zone_r == $past(cfg_dead_zone), "dead zone write lost")
endmodule

FILE: tb/sv/tb_holonomic_drive_mixer_top.sv
// Self-checking testbench for holonomic_drive_mixer_top: joystick samples in,
// predicted wheel powers compared per transaction. Depends on hdm_pkg and the RTL.
`timescale 1ns / 1ps
module tb_holonomic_drive_mixer_top;
  import hdm_pkg::*;

  localparam int LATENCY    = 22;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] turn;
  } sample_t;

  typedef struct packed {
    logic signed [7:0] fl;
    logic signed [7:0] fr;
    logic signed [7:0] br;
    logic signed [7:0] bl;
  } wheels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [7:0] in_stick_x = '0, in_stick_y = '0, in_turn_axis = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [7:0] out_fl, out_fr, out_br, out_bl;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_dead_zone = '0;

  always #5 clk = ~clk;

  holonomic_drive_mixer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stick_x(in_stick_x), .in_stick_y(in_stick_y), .in_turn_axis(in_turn_axis),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_front_left_power(out_fl), .out_front_right_power(out_fr),
    .out_back_right_power(out_br), .out_back_left_power(out_bl),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_dead_zone(cfg_dead_zone)
  );

  // Predictor state: the dead zone as the block should currently hold it.
  logic [6:0] dz_model = DEAD_ZONE_RESET;

  sample_t pending_samples[$];   // filled by the stimulus, drained by the driver
  wheels_t expected_wheels[$];   // predicted at input acceptance
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;         // stretch with no random idling
  bit      hold_off = 1'b0;      // receiver hold-off request
  int      hold_count = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Q8 term plus rotation, truncated toward zero and clamped to +-100.
  function automatic logic signed [7:0] clamp_wheel(int term, int rq);
    int v;
    v = (term + rq) / 256;
    if (v > 100) v = 100;
    if (v < -100) v = -100;
    return v[7:0];
  endfunction

  function automatic wheels_t mix_sample(sample_t s, logic [6:0] dz);
    int x, y, rot, rq, sum, pw, pa, a, b, c, d;
    longint ratio;
    wheels_t w;
    x = s.x;
    y = -int'(s.y);  // -128 becomes +128, no wrap
    rot = (int'(s.turn) * 100) / 127;
    rq = rot * 256;
    if ((x < 0 ? -x : x) < int'(dz)) x = 0;
    if ((y < 0 ? -y : y) < int'(dz)) y = 0;
    sum = x * x + y * y;
    pw = int'((floor_sqrt(longint'(sum) << 16) * 100) / 127);
    pa = 0;
    if (sum != 0) begin
      ratio = (longint'(x * x - y * y) * 32768) / longint'(sum);
      pa = int'((longint'(pw) * ratio) / 32768);
    end
    // Quadrants first, then the four axis directions, then centered stick.
    if (y < 0 && x > 0) begin
      a = pw; b = -pa; c = -pa; d = pw;
    end else if (y < 0 && x < 0) begin
      a = -pa; b = pw; c = pw; d = -pa;
    end else if (y > 0 && x < 0) begin
      a = -pw; b = pa; c = pa; d = -pw;
    end else if (y > 0 && x > 0) begin
      a = pa; b = -pw; c = -pw; d = pa;
    end else if (x == 0 && y < 0) begin
      a = pw; b = pw; c = pw; d = pw;
    end else if (x == 0 && y > 0) begin
      a = -pw; b = -pw; c = -pw; d = -pw;
    end else if (y == 0 && x > 0) begin
      a = pw; b = -pw; c = -pw; d = pw;
    end else if (y == 0 && x < 0) begin
      a = -pw; b = pw; c = pw; d = -pw;
    end else begin
      a = 0; b = 0; c = 0; d = 0;
    end
    // Rotation adds on FL/BR and subtracts on FR/BL.
    w.fl = clamp_wheel(a, rq);
    w.fr = clamp_wheel(b, -rq);
    w.br = clamp_wheel(c, rq);
    w.bl = clamp_wheel(d, -rq);
    return w;
  endfunction

  // Driver: valid is independent of stall, payload held while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_wheels.push_back(
          mix_sample({in_stick_x, in_stick_y, in_turn_axis}, dz_model));
        void'(pending_samples.pop_front());
      end
      if (!in_valid || !in_stall) begin
        // pop happened above if accepted; look at the next one
        if (pending_samples.size() != 0 && (quiet || $urandom_range(99) >= 17)) begin
          in_valid     <= 1'b1;
          in_stick_x   <= pending_samples[0].x;
          in_stick_y   <= pending_samples[0].y;
          in_turn_axis <= pending_samples[0].turn;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or held high during a requested hold-off.
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      hold_count <= 0;
      out_stall  <= !quiet && ($urandom_range(99) < 17);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_wheels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d %0d %0d %0d", out_fl, out_fr, out_br, out_bl);
      end else begin
        wheels_t e;
        e = expected_wheels.pop_front();
        if (e != {out_fl, out_fr, out_br, out_bl}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp FL %0d FR %0d BR %0d BL %0d got %0d %0d %0d %0d",
                     e.fl, e.fr, e.br, e.bl, out_fl, out_fr, out_br, out_bl);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction at either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_samples.size() != 0 || expected_wheels.size() != 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_dead_zone(logic [6:0] v);
    cfg_valid     <= 1'b1;
    cfg_dead_zone <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dz_model = v;
  endtask

  function automatic logic signed [7:0] rand_axis();
    case ($urandom_range(7))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return 8'($urandom_range(20));
      3: return -8'($urandom_range(20));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    sample_t s;
    repeat (n) begin
      s.x = rand_axis();
      s.y = rand_axis();
      s.turn = ($urandom_range(3) == 0) ? 8'sd0 : rand_axis();
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    logic signed [7:0] ax[5];
    ax = '{-8'sd128, -8'sd9, 8'sd0, 8'sd10, 8'sd127};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every quadrant, axis, centered stick, extremes, turn limits.
    foreach (ax[i]) foreach (ax[j])
      pending_samples.push_back('{ax[i], ax[j], (i + j) % 3 == 0 ? 8'sd127 :
                                 ((i + j) % 3 == 1 ? -8'sd128 : 8'sd0)});
    drain();

    // Receiver holds off long enough to fill the pipeline while items keep coming.
    queue_random(120);
    quiet = 1'b1;
    hold_off = 1'b1;
    wait (hold_count >= 200);
    hold_off = 1'b0;
    drain();
    queue_random(150);
    drain();
    quiet = 1'b0;

    foreach (ax[k]) begin
      logic [6:0] dz;
      dz = (k == 0) ? 7'd0 : (k == 1) ? 7'd127 : (k == 4) ? DEAD_ZONE_RESET
           : 7'($urandom_range(1, 126));
      write_dead_zone(dz);
      queue_random(200);
      drain();
    end

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
